// ===== hdl/lha_pkg.sv =====
// Shared types and constants for the LHA header stream parser.
package lha_pkg;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_FIXED    = 4'd1,
    PH_NAMELEN  = 4'd2,
    PH_NAME     = 4'd3,
    PH_CRC      = 4'd4,
    PH_OS       = 4'd5,
    PH_L0EXTRA  = 4'd6,
    PH_EXTSIZE  = 4'd7,
    PH_EXTTYPE  = 4'd8,
    PH_EXTDATA  = 4'd9,
    PH_PAYLOAD  = 4'd10
  } phase_t;

  typedef enum logic [4:0] {
    ROLE_SIZE     = 5'd0,
    ROLE_SUM      = 5'd1,
    ROLE_METHOD   = 5'd2,
    ROLE_CSIZE    = 5'd3,
    ROLE_OSIZE    = 5'd4,
    ROLE_TIME     = 5'd5,
    ROLE_DATE     = 5'd6,
    ROLE_ATTR     = 5'd7,
    ROLE_LEVEL    = 5'd8,
    ROLE_NAMELEN  = 5'd9,
    ROLE_NAME     = 5'd10,
    ROLE_CRC      = 5'd11,
    ROLE_OS       = 5'd12,
    ROLE_L0EXTRA  = 5'd13,
    ROLE_EXTSIZE  = 5'd14,
    ROLE_EXTTYPE  = 5'd15,
    ROLE_EXTNAME  = 5'd16,
    ROLE_EXTDIR   = 5'd17,
    ROLE_EXTSKIP  = 5'd18,
    ROLE_PAYLOAD  = 5'd19,
    ROLE_IGNORED  = 5'd20
  } role_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_SUM    = 3'd1,
    ERR_LEVEL  = 3'd2,
    ERR_DATA   = 3'd3,
    ERR_L0SIZE = 3'd4,
    ERR_EMPTY  = 3'd5,
    ERR_L2SIZE = 3'd6
  } err_t;

  localparam logic [32:0] MinHeader = 33'd22;
  localparam logic [16:0] LevelOffset = 17'd20;
  localparam logic [7:0] ExtName = 8'h01;
  localparam logic [7:0] ExtDir = 8'h02;
  localparam logic [7:0] ByteFf = 8'hFF;
  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] Slash = 8'h2F;

endpackage

// ===== hdl/lha_header_stream_parser.sv =====
// Top level of the LHA header stream parser.
//
// Archive bytes enter on the input channel (in_valid / in_stall), one per
// request; every byte yields exactly one result request on the output
// channel (out_valid / out_stall) labelling the byte's role in the archive.
// The archive length is written on the cfg channel (cfg_valid / cfg_ready);
// the user must write it only while the block is idle; no logic enforces
// this. The register is always ready; each byte's result is registered.
// Throughput: one byte per cycle while in_stall is low. All parse state
// updates in one pass of logic between the input and the result register;
// the per-byte state update (32-bit length compares) sets the figure.
// When the receiver stalls, the result is held and a second result waits
// in a skid register; input stalls only once both hold data.
// Reset (rst, synchronous, active high) returns the parser to a header
// start with no error, clears both result slots and the archive length.
// After an error or the normal end, bytes are still taken and marked
// ignored; error_code and archive_end stay until reset.
module lha_header_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  byte_role,
  output logic [7:0]  out_byte,
  output logic [31:0] field_value,
  output logic        field_done,
  output logic        header_end,
  output logic [31:0] payload_length,
  output logic [2:0]  error_code,
  output logic        archive_end
);
  import lha_pkg::*;

  typedef struct packed {
    logic [4:0]  role;
    logic [7:0]  ob;
    logic [31:0] fv;
    logic        fd;
    logic        he;
    logic [31:0] pl;
    logic [2:0]  err;
    logic        fin;
  } res_t;

  // parse state
  logic [31:0] archive_length;
  logic [31:0] stream_position;
  logic [15:0] header_byte_count;
  logic        count_over;
  phase_t      parse_phase;
  logic [31:0] field_accumulator;
  logic [2:0]  field_byte_index;
  logic [1:0]  header_level;
  logic [15:0] first_two_bytes;
  logic [7:0]  running_sum;
  logic [31:0] pack_size;
  logic [7:0]  name_remaining;
  logic [15:0] extension_remaining;
  logic [7:0]  extension_type;
  logic [31:0] payload_remaining;
  logic [2:0]  sticky_error;
  logic        finished;
  logic        sum_pending;

  logic [31:0] stream_position_next;
  logic [15:0] header_byte_count_next;
  logic        count_over_next;
  phase_t      parse_phase_next;
  logic [31:0] field_accumulator_next;
  logic [2:0]  field_byte_index_next;
  logic [1:0]  header_level_next;
  logic [15:0] first_two_bytes_next;
  logic [7:0]  running_sum_next;
  logic [31:0] pack_size_next;
  logic [7:0]  name_remaining_next;
  logic [15:0] extension_remaining_next;
  logic [7:0]  extension_type_next;
  logic [31:0] payload_remaining_next;
  logic [2:0]  sticky_error_next;
  logic        finished_next;
  logic        sum_pending_next;

  // result slots: main output register plus a skid stage
  res_t main_q, skid_q, res;
  logic main_v, skid_v;

  logic accept;
  assign cfg_ready = 1'b1;
  assign in_stall = skid_v;
  assign accept = in_valid && !skid_v;
  assign out_valid = main_v;

  assign byte_role      = main_q.role;
  assign out_byte       = main_q.ob;
  assign field_value    = main_q.fv;
  assign field_done     = main_q.fd;
  assign header_end     = main_q.he;
  assign payload_length = main_q.pl;
  assign error_code     = main_q.err;
  assign archive_end    = main_q.fin;

  always_comb begin
    logic [32:0] rem_after, rem_now;
    logic [16:0] offset, size1, hb, need;
    logic [7:0]  b;
    logic [31:0] acc;
    logic [2:0]  idx;
    logic        took, stop;
    logic [4:0]  role;
    logic [7:0]  ob;
    logic [31:0] fv, pl;
    logic        fd, he;
    logic [15:0] e;
    logic [2:0]  nbytes;

    b = data_byte;
    role = ROLE_IGNORED;
    ob = b;
    fv = '0;
    fd = 1'b0;
    he = 1'b0;
    pl = '0;
    stop = 1'b0;
    took = 1'b0;
    acc = '0;
    idx = '0;
    e = '0;
    hb = '0;
    need = '0;
    nbytes = 3'd4;

    stream_position_next = stream_position + 32'd1;
    header_byte_count_next = header_byte_count;
    count_over_next = count_over;
    parse_phase_next = parse_phase;
    field_accumulator_next = field_accumulator;
    field_byte_index_next = field_byte_index;
    header_level_next = header_level;
    first_two_bytes_next = first_two_bytes;
    running_sum_next = running_sum;
    pack_size_next = pack_size;
    name_remaining_next = name_remaining;
    extension_remaining_next = extension_remaining;
    extension_type_next = extension_type;
    payload_remaining_next = payload_remaining;
    sticky_error_next = sticky_error;
    finished_next = finished;
    sum_pending_next = sum_pending;

    rem_now = {1'b0, archive_length} - {1'b0, stream_position};
    rem_after = ({1'b0, stream_position} + 33'd1 < {1'b0, archive_length}) ?
                ({1'b0, archive_length} - {1'b0, stream_position} - 33'd1) : '0;
    offset = '0;
    size1 = '0;

    if (finished || sticky_error != ERR_NONE) begin
      stop = 1'b1;
    end else if (stream_position >= archive_length) begin
      sticky_error_next = ERR_DATA;
      stop = 1'b1;
    end else if (parse_phase == PH_START && rem_now < MinHeader) begin
      finished_next = 1'b1;
      stop = 1'b1;
    end

    if (!stop) begin
      if (parse_phase == PH_START) begin
        header_byte_count_next = '0;
        count_over_next = 1'b0;
        running_sum_next = '0;
        sum_pending_next = 1'b1;
        field_accumulator_next = '0;
        field_byte_index_next = '0;
        header_level_next = '0;
        first_two_bytes_next = '0;
        pack_size_next = '0;
        parse_phase_next = PH_FIXED;
      end
      offset = count_over_next ? 17'h10000 : {1'b0, header_byte_count_next};
      if (header_byte_count_next == 16'hFFFF) count_over_next = 1'b1;
      header_byte_count_next = header_byte_count_next + 16'd1;
      size1 = {9'd0, first_two_bytes_next[7:0]} + 17'd1;

      if (sum_pending_next && offset >= 17'd2 && offset <= size1)
        running_sum_next = running_sum_next + b;
      if (offset > LevelOffset && sum_pending_next && header_level_next <= 2'd1 &&
          offset >= size1) begin
        sum_pending_next = 1'b0;
        if (running_sum_next != first_two_bytes_next[15:8]) begin
          sticky_error_next = ERR_SUM;
          stop = 1'b1;
        end
      end
    end

    // field accumulation for multibyte numeric fields
    if (!stop) begin
      unique case (parse_phase_next)
        PH_FIXED: nbytes = (offset <= 17'd14) ? 3'd4 : 3'd2;
        default:  nbytes = 3'd2;
      endcase
      acc = field_accumulator_next |
            ({24'd0, b} << {field_byte_index_next[1:0], 3'b000});
      idx = field_byte_index_next + 3'd1;
      took = (idx >= nbytes);
    end

    if (!stop) begin
      unique case (parse_phase_next)
        PH_FIXED: begin
          if (offset == 17'd0) begin
            role = ROLE_SIZE; fd = 1'b1; fv = {24'd0, b};
            first_two_bytes_next = {8'd0, b};
          end else if (offset == 17'd1) begin
            role = ROLE_SUM; fd = 1'b1;
            first_two_bytes_next = {b, first_two_bytes_next[7:0]};
            fv = {16'd0, b, first_two_bytes_next[7:0]};
          end else if (offset <= 17'd6) begin
            role = ROLE_METHOD;
          end else if (offset <= 17'd18) begin
            if (offset <= 17'd10) role = ROLE_CSIZE;
            else if (offset <= 17'd14) role = ROLE_OSIZE;
            else if (offset <= 17'd16) role = ROLE_TIME;
            else role = ROLE_DATE;
            if (took) begin
              fd = 1'b1; fv = acc;
              if (offset <= 17'd10) pack_size_next = acc;
              field_accumulator_next = '0;
              field_byte_index_next = '0;
            end else begin
              field_accumulator_next = acc;
              field_byte_index_next = idx;
            end
          end else if (offset == 17'd19) begin
            role = ROLE_ATTR; fd = 1'b1; fv = {24'd0, b};
          end else begin
            role = ROLE_LEVEL; fd = 1'b1; fv = {24'd0, b};
            header_level_next = b[1:0];
            if (b > 8'd2) begin
              sticky_error_next = ERR_LEVEL;
            end else if (b == 8'd0 && first_two_bytes_next == 16'd0) begin
              finished_next = 1'b1;
            end else if (b == 8'd2) begin
              sum_pending_next = 1'b0;
              parse_phase_next = PH_CRC;
            end else begin
              if (offset >= size1 && sum_pending_next) begin
                sum_pending_next = 1'b0;
                if (running_sum_next != first_two_bytes_next[15:8])
                  sticky_error_next = ERR_SUM;
              end else if (offset >= size1) begin
                sum_pending_next = 1'b0;
                if (running_sum_next != first_two_bytes_next[15:8])
                  sticky_error_next = ERR_SUM;
              end
              parse_phase_next = PH_NAMELEN;
            end
          end
        end
        PH_NAMELEN: begin
          role = ROLE_NAMELEN; fd = 1'b1; fv = {24'd0, b};
          name_remaining_next = b;
          if (rem_after < {25'd0, b}) sticky_error_next = ERR_DATA;
          else parse_phase_next = (b == 8'd0) ? PH_CRC : PH_NAME;
        end
        PH_NAME: begin
          role = ROLE_NAME;
          if (header_level_next == 2'd0 && b == Backslash) ob = Slash;
          name_remaining_next = name_remaining_next - 8'd1;
          if (name_remaining_next == 8'd0) parse_phase_next = PH_CRC;
        end
        PH_CRC: begin
          role = ROLE_CRC;
          if (took) begin
            fd = 1'b1; fv = acc;
            field_accumulator_next = '0;
            field_byte_index_next = '0;
            if (header_level_next != 2'd0) begin
              parse_phase_next = PH_OS;
            end else begin
              hb = offset + 17'd1;
              need = size1 + 17'd1;
              if (hb < need) begin
                sticky_error_next = ERR_L0SIZE;
              end else if (hb > need) begin
                if (rem_after < {16'd0, hb - need}) begin
                  sticky_error_next = ERR_DATA;
                end else begin
                  extension_remaining_next = 16'(hb - need);
                  parse_phase_next = PH_L0EXTRA;
                end
              end else begin
                he = 1'b1;
              end
            end
          end else begin
            field_accumulator_next = acc;
            field_byte_index_next = idx;
          end
        end
        PH_L0EXTRA: begin
          role = ROLE_L0EXTRA;
          extension_remaining_next = extension_remaining_next - 16'd1;
          if (extension_remaining_next == 16'd0) he = 1'b1;
        end
        PH_OS: begin
          role = ROLE_OS; fd = 1'b1; fv = {24'd0, b};
          parse_phase_next = PH_EXTSIZE;
        end
        PH_EXTSIZE: begin
          role = ROLE_EXTSIZE;
          if (took) begin
            fd = 1'b1; fv = acc;
            field_accumulator_next = '0;
            field_byte_index_next = '0;
            if (acc == 32'd0) begin
              if (header_level_next == 2'd2 &&
                  (count_over_next || (offset + 17'd1) != {1'b0, first_two_bytes_next}))
                sticky_error_next = ERR_L2SIZE;
              else
                he = 1'b1;
            end else begin
              if (header_level_next == 2'd1)
                pack_size_next = pack_size_next - acc;
              e = acc[15:0] - 16'd2;
              if (rem_after < {17'd0, e}) sticky_error_next = ERR_DATA;
              else if (e == 16'd0) sticky_error_next = ERR_EMPTY;
              else begin
                extension_remaining_next = e;
                parse_phase_next = PH_EXTTYPE;
              end
            end
          end else begin
            field_accumulator_next = acc;
            field_byte_index_next = idx;
          end
        end
        PH_EXTTYPE: begin
          role = ROLE_EXTTYPE; fd = 1'b1; fv = {24'd0, b};
          extension_type_next = b;
          extension_remaining_next = extension_remaining_next - 16'd1;
          parse_phase_next = (extension_remaining_next == 16'd0) ? PH_EXTSIZE : PH_EXTDATA;
        end
        PH_EXTDATA: begin
          if (extension_type_next == ExtName) begin
            role = ROLE_EXTNAME;
          end else if (extension_type_next == ExtDir) begin
            role = ROLE_EXTDIR;
            if (b == ByteFf) ob = Slash;
          end else begin
            role = ROLE_EXTSKIP;
          end
          extension_remaining_next = extension_remaining_next - 16'd1;
          if (extension_remaining_next == 16'd0) parse_phase_next = PH_EXTSIZE;
        end
        PH_PAYLOAD: begin
          role = ROLE_PAYLOAD;
          payload_remaining_next = payload_remaining_next - 32'd1;
          if (payload_remaining_next == 32'd0) begin
            parse_phase_next = PH_START;
            if (rem_after < MinHeader) finished_next = 1'b1;
          end
        end
        default: parse_phase_next = PH_START;
      endcase

      // header end: pending level-1 sum, then payload fit check
      if (he) begin
        pl = pack_size_next;
        if (header_level_next == 2'd1 && sum_pending_next) begin
          sum_pending_next = 1'b0;
          if (running_sum_next != first_two_bytes_next[15:8])
            sticky_error_next = ERR_SUM;
        end
        if (sticky_error_next == ERR_NONE) begin
          if (rem_after < {1'b0, pack_size_next}) begin
            sticky_error_next = ERR_DATA;
          end else if (pack_size_next == 32'd0) begin
            parse_phase_next = PH_START;
            if (rem_after < MinHeader) finished_next = 1'b1;
          end else begin
            payload_remaining_next = pack_size_next;
            parse_phase_next = PH_PAYLOAD;
          end
        end
      end

      if (!finished_next && sticky_error_next == ERR_NONE &&
          parse_phase_next != PH_START && rem_after == '0)
        sticky_error_next = ERR_DATA;
    end

    res.role = role;
    res.ob = ob;
    res.fv = fv;
    res.fd = fd;
    res.he = he;
    res.pl = pl;
    res.err = sticky_error_next;
    res.fin = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      archive_length <= '0;
      stream_position <= '0;
      header_byte_count <= '0;
      count_over <= 1'b0;
      parse_phase <= PH_START;
      field_accumulator <= '0;
      field_byte_index <= '0;
      header_level <= '0;
      first_two_bytes <= '0;
      running_sum <= '0;
      pack_size <= '0;
      name_remaining <= '0;
      extension_remaining <= '0;
      extension_type <= '0;
      payload_remaining <= '0;
      sticky_error <= ERR_NONE;
      finished <= 1'b0;
      sum_pending <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) archive_length <= cfg_data;
      if (accept) begin
        stream_position <= stream_position_next;
        header_byte_count <= header_byte_count_next;
        count_over <= count_over_next;
        parse_phase <= parse_phase_next;
        field_accumulator <= field_accumulator_next;
        field_byte_index <= field_byte_index_next;
        header_level <= header_level_next;
        first_two_bytes <= first_two_bytes_next;
        running_sum <= running_sum_next;
        pack_size <= pack_size_next;
        name_remaining <= name_remaining_next;
        extension_remaining <= extension_remaining_next;
        extension_type <= extension_type_next;
        payload_remaining <= payload_remaining_next;
        sticky_error <= sticky_error_next;
        finished <= finished_next;
        sum_pending <= sum_pending_next;
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!main_v || !out_stall) begin
        if (skid_v) begin
          main_q <= skid_q;
          main_v <= 1'b1;
          skid_v <= 1'b0;
        end else begin
          main_v <= accept;
          if (accept) main_q <= res;
        end
      end else if (accept) begin
        skid_q <= res;
        skid_v <= 1'b1;
      end
    end
  end

endmodule
